@@ sv/complex_arithmetic_unit_macros.svh @@
// Assertion helpers for the file that checks itself.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cau_pkg.sv @@
package cau_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int QUOT_W        = 32;
  localparam int DEN_W         = 64;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 66;
  localparam int OP_W          = 2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic              is_div;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic              sat;
    logic [DATA_W-1:0] res_re;
    logic [DATA_W-1:0] res_im;
  } side_t;

endpackage

@@ sv/cau_divider.sv @@
module cau_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [cau_pkg::DEN_W-1:0]   in_rem_re,
  input  logic [cau_pkg::QUOT_W-1:0]  in_low_re,
  input  logic [cau_pkg::DEN_W-1:0]   in_rem_im,
  input  logic [cau_pkg::QUOT_W-1:0]  in_low_im,
  input  logic [cau_pkg::DEN_W-1:0]   in_den,
  input  cau_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [cau_pkg::QUOT_W-1:0]  out_q_re,
  output logic [cau_pkg::QUOT_W-1:0]  out_q_im,
  output cau_pkg::side_t              out_side
);
  import cau_pkg::*;

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [DEN_W:0] div_step(logic [DEN_W-1:0] rem, logic b,
                                              logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic [DEN_W:0] d;
    t = {rem, b};
    d = {1'b0, den};
    if (t >= d) begin
      t = t - d;
      return {1'b1, t[DEN_W-1:0]};
    end
    return {1'b0, t[DEN_W-1:0]};
  endfunction

  logic [QUOT_W-1:0]           valid;
  logic [DEN_W-1:0]            rem_re [QUOT_W];
  logic [DEN_W-1:0]            rem_im [QUOT_W];
  logic [QUOT_W-1:0]           bits_re [QUOT_W];
  logic [QUOT_W-1:0]           bits_im [QUOT_W];
  logic [DEN_W-1:0]            den [QUOT_W];
  side_t                       side [QUOT_W];

  for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
    logic              src_valid;
    logic [DEN_W-1:0]  src_rem_re;
    logic [DEN_W-1:0]  src_rem_im;
    logic [QUOT_W-1:0] src_bits_re;
    logic [QUOT_W-1:0] src_bits_im;
    logic [DEN_W-1:0]  src_den;
    side_t             src_side;
    logic [DEN_W:0]    st_re;
    logic [DEN_W:0]    st_im;

    if (k == 0) begin : g_first
      assign src_valid   = in_valid;
      assign src_rem_re  = in_rem_re;
      assign src_rem_im  = in_rem_im;
      assign src_bits_re = in_low_re;
      assign src_bits_im = in_low_im;
      assign src_den     = in_den;
      assign src_side    = in_side;
    end else begin : g_next
      assign src_valid   = valid[k-1];
      assign src_rem_re  = rem_re[k-1];
      assign src_rem_im  = rem_im[k-1];
      assign src_bits_re = bits_re[k-1];
      assign src_bits_im = bits_im[k-1];
      assign src_den     = den[k-1];
      assign src_side    = side[k-1];
    end

    assign st_re = div_step(src_rem_re, src_bits_re[QUOT_W-1], src_den);
    assign st_im = div_step(src_rem_im, src_bits_im[QUOT_W-1], src_den);

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_re[k]  <= st_re[DEN_W-1:0];
        rem_im[k]  <= st_im[DEN_W-1:0];
        bits_re[k] <= {src_bits_re[QUOT_W-2:0], st_re[DEN_W]};
        bits_im[k] <= {src_bits_im[QUOT_W-2:0], st_im[DEN_W]};
        den[k]     <= src_den;
        side[k]    <= src_side;
      end
    end
  end

  assign out_valid = valid[QUOT_W-1];
  assign out_q_re  = bits_re[QUOT_W-1];
  assign out_q_im  = bits_im[QUOT_W-1];
  assign out_side  = side[QUOT_W-1];

endmodule

@@ sv/complex_arithmetic_unit.sv @@
// Complex add, subtract, multiply and divide on signed fixed-point operands with FRAC_BITS
// fractional bits. It takes one transaction per clock while the skid register is empty and
// returns each result in order of arrival, after stages for the products, sums, magnitudes
// and saturation, a pipelined restoring divider that gives one quotient bit per stage, and
// an output register that selects the result. Every operation passes through all stages, so
// the latency does not depend on the operation. A stalled output is held in a skid register;
// while it is full the pipeline holds and no new transaction is taken.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // a_real, a_imag, b_real, b_imag
  input  logic [4*cau_pkg::DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [cau_pkg::OP_W-1:0]      s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // result_real, result_imag
  output logic [2*cau_pkg::DATA_W-1:0]  m_axis_tdata,
  // div_by_zero, saturated
  output logic [1:0]                    m_axis_tuser
);
  import cau_pkg::*;

  localparam int NUM_W = DEN_W + FRAC_BITS;

  function automatic logic [DATA_W:0] sat_part(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = SUM_W'($signed({1'b0, {(DATA_W-1){1'b1}}}));
    lo_lim = SUM_W'($signed({1'b1, {(DATA_W-1){1'b0}}}));
    if (v > hi_lim) begin
      return {1'b1, hi_lim[DATA_W-1:0]};
    end
    if (v < lo_lim) begin
      return {1'b1, lo_lim[DATA_W-1:0]};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  function automatic logic [DATA_W:0] quot_part(logic [QUOT_W-1:0] q, logic neg, logic ovf);
    logic [DATA_W-1:0] lim;
    lim = {1'b1, {(DATA_W-1){1'b0}}};
    if (neg) begin
      if (ovf || (q > lim)) begin
        return {1'b1, lim};
      end
      return {1'b0, DATA_W'(-q)};
    end
    if (ovf || q[QUOT_W-1]) begin
      return {1'b1, ~lim};
    end
    return {1'b0, q};
  endfunction

  logic en;

  // Products.
  logic                       p_valid;
  logic [OP_W-1:0]            p_op;
  logic signed [DATA_W-1:0]   p_are, p_aim, p_bre, p_bim;
  logic signed [PROD_W-1:0]   p_rr, p_ii, p_ri, p_ir, p_sr, p_si;

  // Sums.
  logic                       s_valid;
  logic [OP_W-1:0]            s_op;
  logic signed [SUM_W-1:0]    s_re, s_im, s_re_next, s_im_next;
  logic [DEN_W-1:0]           s_den;

  // Magnitudes.
  logic                       m_valid;
  logic [OP_W-1:0]            m_op;
  logic signed [SUM_W-1:0]    m_re, m_im;
  logic [DEN_W-1:0]           m_mag_re, m_mag_im, m_den;
  logic                       m_neg_re, m_neg_im;
  logic [SUM_W-1:0]           neg_re, neg_im;

  // Saturation and divider set-up.
  logic                       c_valid;
  side_t                      c_side, c_side_next;
  logic [DEN_W-1:0]           c_rem_re, c_rem_im, c_den;
  logic [QUOT_W-1:0]          c_low_re, c_low_im;
  logic [NUM_W-1:0]           num_re, num_im;
  logic [DEN_W-1:0]           rem_re_next, rem_im_next;
  logic signed [SUM_W-1:0]    sh_re, sh_im;
  logic [DATA_W:0]            sp_re, sp_im;

  // Divider outputs.
  logic                       d_valid;
  logic [QUOT_W-1:0]          d_q_re, d_q_im;
  side_t                      d_side;

  // Output stage and skid register.
  logic                       o_valid;
  logic [DATA_W-1:0]          o_re, o_im, o_re_next, o_im_next;
  logic                       o_dz, o_sat, o_sat_next;
  logic [DATA_W:0]            qp_re, qp_im;
  logic                       sk_valid;
  logic [DATA_W-1:0]          sk_re, sk_im;
  logic                       sk_dz, sk_sat;

  assign en            = !sk_valid;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      m_valid <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_axis_tvalid;
      s_valid <= p_valid;
      m_valid <= s_valid;
      c_valid <= m_valid;
      o_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_op  <= s_axis_tuser;
      p_are <= s_axis_tdata[DATA_W-1:0];
      p_aim <= s_axis_tdata[2*DATA_W-1:DATA_W];
      p_bre <= s_axis_tdata[3*DATA_W-1:2*DATA_W];
      p_bim <= s_axis_tdata[4*DATA_W-1:3*DATA_W];
      p_rr  <= PROD_W'($signed(s_axis_tdata[DATA_W-1:0]))
             * PROD_W'($signed(s_axis_tdata[3*DATA_W-1:2*DATA_W]));
      p_ii  <= PROD_W'($signed(s_axis_tdata[2*DATA_W-1:DATA_W]))
             * PROD_W'($signed(s_axis_tdata[4*DATA_W-1:3*DATA_W]));
      p_ri  <= PROD_W'($signed(s_axis_tdata[DATA_W-1:0]))
             * PROD_W'($signed(s_axis_tdata[4*DATA_W-1:3*DATA_W]));
      p_ir  <= PROD_W'($signed(s_axis_tdata[2*DATA_W-1:DATA_W]))
             * PROD_W'($signed(s_axis_tdata[3*DATA_W-1:2*DATA_W]));
      p_sr  <= PROD_W'($signed(s_axis_tdata[3*DATA_W-1:2*DATA_W]))
             * PROD_W'($signed(s_axis_tdata[3*DATA_W-1:2*DATA_W]));
      p_si  <= PROD_W'($signed(s_axis_tdata[4*DATA_W-1:3*DATA_W]))
             * PROD_W'($signed(s_axis_tdata[4*DATA_W-1:3*DATA_W]));
    end
  end

  always_comb begin
    case (p_op)
      OP_ADD: begin
        s_re_next = SUM_W'(p_are) + SUM_W'(p_bre);
        s_im_next = SUM_W'(p_aim) + SUM_W'(p_bim);
      end
      OP_SUB: begin
        s_re_next = SUM_W'(p_are) - SUM_W'(p_bre);
        s_im_next = SUM_W'(p_aim) - SUM_W'(p_bim);
      end
      OP_MUL: begin
        s_re_next = SUM_W'(p_rr) - SUM_W'(p_ii);
        s_im_next = SUM_W'(p_ri) + SUM_W'(p_ir);
      end
      default: begin
        s_re_next = SUM_W'(p_rr) + SUM_W'(p_ii);
        s_im_next = SUM_W'(p_ir) - SUM_W'(p_ri);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_op  <= p_op;
      s_re  <= s_re_next;
      s_im  <= s_im_next;
      s_den <= DEN_W'(p_sr) + DEN_W'(p_si);
    end
  end

  assign neg_re = -s_re;
  assign neg_im = -s_im;

  always_ff @(posedge clk) begin
    if (en) begin
      m_op     <= s_op;
      m_re     <= s_re;
      m_im     <= s_im;
      m_den    <= s_den;
      m_neg_re <= s_re[SUM_W-1];
      m_neg_im <= s_im[SUM_W-1];
      m_mag_re <= s_re[SUM_W-1] ? neg_re[DEN_W-1:0] : s_re[DEN_W-1:0];
      m_mag_im <= s_im[SUM_W-1] ? neg_im[DEN_W-1:0] : s_im[DEN_W-1:0];
    end
  end

  always_comb begin
    sh_re       = (m_op == OP_MUL) ? (m_re >>> FRAC_BITS) : m_re;
    sh_im       = (m_op == OP_MUL) ? (m_im >>> FRAC_BITS) : m_im;
    sp_re       = sat_part(sh_re);
    sp_im       = sat_part(sh_im);
    num_re      = NUM_W'(m_mag_re) << FRAC_BITS;
    num_im      = NUM_W'(m_mag_im) << FRAC_BITS;
    rem_re_next = DEN_W'(num_re[NUM_W-1:QUOT_W]);
    rem_im_next = DEN_W'(num_im[NUM_W-1:QUOT_W]);
    c_side_next.is_div = (m_op == OP_DIV);
    c_side_next.dz     = (m_den == '0);
    c_side_next.neg_re = m_neg_re;
    c_side_next.neg_im = m_neg_im;
    c_side_next.ovf_re = (rem_re_next >= m_den);
    c_side_next.ovf_im = (rem_im_next >= m_den);
    c_side_next.sat    = sp_re[DATA_W] | sp_im[DATA_W];
    c_side_next.res_re = sp_re[DATA_W-1:0];
    c_side_next.res_im = sp_im[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_side   <= c_side_next;
      c_rem_re <= rem_re_next;
      c_rem_im <= rem_im_next;
      c_low_re <= num_re[QUOT_W-1:0];
      c_low_im <= num_im[QUOT_W-1:0];
      c_den    <= m_den;
    end
  end

  cau_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_valid),
    .in_rem_re (c_rem_re),
    .in_low_re (c_low_re),
    .in_rem_im (c_rem_im),
    .in_low_im (c_low_im),
    .in_den    (c_den),
    .in_side   (c_side),
    .out_valid (d_valid),
    .out_q_re  (d_q_re),
    .out_q_im  (d_q_im),
    .out_side  (d_side)
  );

  always_comb begin
    qp_re = quot_part(d_q_re, d_side.neg_re, d_side.ovf_re);
    qp_im = quot_part(d_q_im, d_side.neg_im, d_side.ovf_im);
    if (!d_side.is_div) begin
      o_re_next  = d_side.res_re;
      o_im_next  = d_side.res_im;
      o_sat_next = d_side.sat;
    end else if (d_side.dz) begin
      o_re_next  = '0;
      o_im_next  = '0;
      o_sat_next = 1'b0;
    end else begin
      o_re_next  = qp_re[DATA_W-1:0];
      o_im_next  = qp_im[DATA_W-1:0];
      o_sat_next = qp_re[DATA_W] | qp_im[DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_re  <= o_re_next;
      o_im  <= o_im_next;
      o_dz  <= d_side.is_div & d_side.dz;
      o_sat <= o_sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_valid <= 1'b0;
    end else if (sk_valid) begin
      if (m_axis_tready) begin
        sk_valid <= 1'b0;
      end
    end else if (o_valid && !m_axis_tready) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid) begin
      sk_re  <= o_re;
      sk_im  <= o_im;
      sk_dz  <= o_dz;
      sk_sat <= o_sat;
    end
  end

  assign m_axis_tvalid = sk_valid | o_valid;
  assign m_axis_tdata  = sk_valid ? {sk_im, sk_re} : {o_im, o_re};
  assign m_axis_tuser  = sk_valid ? {sk_sat, sk_dz} : {o_sat, o_dz};

  `include "complex_arithmetic_unit_macros.svh"

  `CAU_ASSERT_NOW(a_div_zero_result, clk, rst, m_axis_tvalid && m_axis_tuser[0],
                  (m_axis_tdata == '0) && !m_axis_tuser[1],
                  "Divide by zero must give a zero, unsaturated result.")
  `CAU_ASSERT_NEXT(a_skid_capture, clk, rst, o_valid && !m_axis_tready && !sk_valid,
                   sk_valid, "A stalled result must move into the skid register.")
  `CAU_ASSERT_NOW(a_hold_when_full, clk, rst, sk_valid, !s_axis_tready && m_axis_tvalid,
                  "A full skid register must stall the input and present its result.")

endmodule

@@ tb/complex_arithmetic_unit_tb.sv @@
`timescale 1ns / 1ps

module complex_arithmetic_unit_tb;
  import cau_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        sat;
  } cplx_res_t;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [31:0]     ar, ai, br, bi;
    logic            typed;
    cplx_res_t       res;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [4*DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0] s_axis_tuser = OP_ADD;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [2*DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  cplx_res_t pending_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int quiet_cycles = 0;

  complex_arithmetic_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'h7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [31:0] quotient_part(input logic signed [127:0] num,
                                                input logic [127:0] den, inout logic flag);
    logic [127:0] mag;
    logic [127:0] q;
    mag = num < 0 ? -num : num;
    q = (mag << FRAC_BITS_DEF) / den;
    if (num < 0) begin
      if (q > 128'h8000_0000) begin
        flag = 1'b1;
        q = 128'h8000_0000;
      end
      return -q[31:0];
    end
    if (q > 128'h7fff_ffff) begin
      flag = 1'b1;
      q = 128'h7fff_ffff;
    end
    return q[31:0];
  endfunction

  function automatic cplx_res_t complex_op(input logic [OP_W-1:0] op,
                                           input logic signed [31:0] ar, ai, br, bi);
    cplx_res_t r;
    logic signed [127:0] xr, xi, yr, yi;
    logic [127:0] den;
    xr = 128'(ar);
    xi = 128'(ai);
    yr = 128'(br);
    yi = 128'(bi);
    r = '{re: '0, im: '0, dz: 1'b0, sat: 1'b0};
    case (op)
      OP_ADD: begin
        r.re = clamp32(xr + yr, r.sat);
        r.im = clamp32(xi + yi, r.sat);
      end
      OP_SUB: begin
        r.re = clamp32(xr - yr, r.sat);
        r.im = clamp32(xi - yi, r.sat);
      end
      OP_MUL: begin
        r.re = clamp32((xr * yr - xi * yi) >>> FRAC_BITS_DEF, r.sat);
        r.im = clamp32((xr * yi + xi * yr) >>> FRAC_BITS_DEF, r.sat);
      end
      default: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          r.re = quotient_part(xr * yr + xi * yi, den, r.sat);
          r.im = quotient_part(xi * yr - xr * yi, den, r.sat);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      2: begin
        case ($urandom_range(5))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          4: return 32'h0001_0000;
          default: return 32'h0000_0001;
        endcase
      end
      3: return $signed($urandom) >>> $urandom_range(31);
      default: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
    endcase
  endfunction

  task automatic send_vec(input vec_t v);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= v.op;
    s_axis_tdata <= {v.bi, v.br, v.ai, v.ar};
    do @(posedge clk); while (!s_axis_tready);
    if (v.typed)
      pending_q.push_back(v.res);
    else
      pending_q.push_back(complex_op(v.op, v.ar, v.ai, v.br, v.bi));
  endtask

  task automatic send_random(input int count);
    vec_t v;
    repeat (count) begin
      v.op = OP_W'($urandom_range(3));
      v.ar = pick_operand();
      v.ai = pick_operand();
      v.br = pick_operand();
      v.bi = pick_operand();
      if (v.op == OP_DIV && $urandom_range(19) == 0) begin
        v.br = '0;
        v.bi = '0;
      end
      v.typed = 1'b0;
      send_vec(v);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cplx_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: actual %h/%b", $time,
                 m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[31:0] !== want.re || m_axis_tdata[63:32] !== want.im ||
            m_axis_tuser[0] !== want.dz || m_axis_tuser[1] !== want.sat) begin
          errors++;
          $display("%0t: expected re %h im %h dz %b sat %b, actual %h %h %b %b",
                   $time, want.re, want.im, want.dz, want.sat, m_axis_tdata[31:0],
                   m_axis_tdata[63:32], m_axis_tuser[0], m_axis_tuser[1]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  vec_t directed[] = '{
    '{OP_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b0, 1'b0}},
    '{OP_ADD, 32'h7fffffff, 32'h1, 32'h1, 32'h2, 1'b1, '{32'h7fffffff, 32'h3, 1'b0, 1'b1}},
    '{OP_ADD, 32'h80000000, 32'h80000000, 32'hffffffff, 32'h80000000, 1'b1,
      '{32'h80000000, 32'h80000000, 1'b0, 1'b1}},
    '{OP_SUB, 32'h80000000, 32'h5, 32'h1, 32'h5, 1'b1, '{32'h80000000, 32'h0, 1'b0, 1'b1}},
    '{OP_SUB, 32'h7fffffff, 32'h0, 32'h80000000, 32'h7fffffff, 1'b1,
      '{32'h7fffffff, 32'h80000001, 1'b0, 1'b1}},
    '{OP_DIV, 32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b0}},
    '{OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{32'h0, 32'h0, 1'b1, 1'b0}},
    '{OP_MUL, 32'h00010000, 32'h0, 32'h00030000, 32'hfffe0000, 1'b1,
      '{32'h00030000, 32'hfffe0000, 1'b0, 1'b0}},
    '{OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '{0, 0, 0, 0}},
    '{OP_MUL, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1'b0, '{0, 0, 0, 0}},
    '{OP_MUL, 32'hffffffff, 32'h1, 32'h1, 32'h1, 1'b0, '{0, 0, 0, 0}},
    '{OP_DIV, 32'h00050000, 32'hfffd0000, 32'h00010000, 32'h0, 1'b1,
      '{32'h00050000, 32'hfffd0000, 1'b0, 1'b0}},
    '{OP_DIV, 32'h7fffffff, 32'h7fffffff, 32'h1, 32'h0, 1'b0, '{0, 0, 0, 0}},
    '{OP_DIV, 32'h80000000, 32'h7fffffff, 32'h0, 32'hffffffff, 1'b0, '{0, 0, 0, 0}},
    '{OP_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b0, '{0, 0, 0, 0}},
    '{OP_DIV, 32'hffffffff, 32'h1, 32'h7fffffff, 32'h80000000, 1'b0, '{0, 0, 0, 0}},
    '{OP_DIV, 32'h00001234, 32'hffff0000, 32'h00030000, 32'h00040000, 1'b0, '{0, 0, 0, 0}}
  };

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_vec(directed[i]);
    wait_drained();

    send_idle = 9;
    recv_idle = 76;
    send_random(400);

    send_idle = 76;
    recv_idle = 9;
    send_random(300);

    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    send_random(350);
    wait_drained();
    send_random(300);

    wait_drained();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
